// ----- rtl/evd_pkg.sv -----
// Shared types and constants for the attack/release envelope detector.
package evd_pkg;

    localparam int SAMPLE_W   = 16;                 // input sample width
    localparam int GAIN_W     = 16;                 // Q0.16 gain registers
    localparam int MAG_W      = 17;                 // integer magnitude
    localparam int ENV_FRAC   = 16;
    localparam int ENV_W      = MAG_W + ENV_FRAC;   // Q17.16 envelope
    localparam int OUT_SHIFT  = 8;
    localparam int OUT_W      = ENV_W - OUT_SHIFT;  // Q17.8 result
    localparam int LOOK_W     = 12;
    localparam int SQ_W       = 2 * SAMPLE_W;       // re^2 + im^2
    localparam int ROOT_W     = SQ_W / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int STEP_W     = $clog2(ROOT_W);
    localparam int MUL_W      = GAIN_W + 1;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [MUL_W-1:0] GAIN_ONE = MUL_W'(1) << GAIN_W;

    localparam logic [CFG_IDX_W-1:0] CFG_COMPLEX   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD = 2'd3;

    localparam logic              RST_COMPLEX   = 1'b1;
    localparam logic [GAIN_W-1:0] RST_ATTACK    = 16'd59294;
    localparam logic [GAIN_W-1:0] RST_RELEASE   = 16'd59294;
    localparam logic [LOOK_W-1:0] RST_LOOKAHEAD = 12'd10;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SQ_RE,
        F_SQ_IM,
        F_ROOT,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL_LO,
        B_MUL_HI,
        B_MUL_MAG,
        B_OUT
    } back_state_t;

    // absolute value of a two's complement sample, one bit wider
    function automatic logic [SAMPLE_W:0] abs_sample(input logic [SAMPLE_W-1:0] v);
        logic [SAMPLE_W:0] ext;
        ext = {v[SAMPLE_W-1], v};
        if (v[SAMPLE_W-1]) begin
            return (~ext) + (SAMPLE_W + 1)'(1);
        end
        return ext;
    endfunction

endpackage

// ----- rtl/evd_front.sv -----
// Front end: takes samples, drops the lookahead run, forms the magnitude.
module evd_front
    import evd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SAMPLE_W-1:0] in_real,
    input  logic [SAMPLE_W-1:0] in_imag,
    input  logic                complex_input,
    input  logic [LOOK_W-1:0]   lookahead_count,
    output logic                mag_valid,
    input  logic                mag_ready,
    output logic [MAG_W-1:0]    mag_data
);

    front_state_t      state_reg, state_next;
    logic [LOOK_W-1:0] skip_reg;
    logic [SAMPLE_W-1:0] re_reg, im_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [STEP_W-1:0] step_reg;
    logic [MAG_W-1:0]  mag_reg;

    logic              accept;
    logic              skipping;
    logic [SAMPLE_W:0] abs_re, abs_im;
    logic [SQ_W+1:0]   square;
    logic [REM_W+1:0]  rem_sh, trial;
    logic              fits;
    logic [ROOT_W-1:0] root_step;

    assign accept   = in_valid && in_ready;
    assign skipping = skip_reg < lookahead_count;
    assign abs_re   = abs_sample(re_reg);
    assign abs_im   = abs_sample(im_reg);
    // one squarer, shared between the two parts
    assign square   = (state_reg == F_SQ_RE) ? abs_re * abs_re : abs_im * abs_im;

    // one result bit per cycle, restoring square root
    assign rem_sh    = {rem_reg, sq_reg[SQ_W-1 -: 2]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign fits      = rem_sh >= trial;
    assign root_step = {root_reg[ROOT_W-2:0], fits};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (accept && !skipping) state_next = F_SQ_RE;
            end
            F_SQ_RE: begin
                state_next = complex_input ? F_SQ_IM : F_PUSH;
            end
            F_SQ_IM: begin
                state_next = F_ROOT;
            end
            F_ROOT: begin
                if (step_reg == '0) state_next = F_PUSH;
            end
            F_PUSH: begin
                if (mag_ready) state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb begin
        in_ready  = (state_reg == F_IDLE);
        mag_valid = (state_reg == F_PUSH);
        mag_data  = mag_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            skip_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (accept && skipping) skip_reg <= skip_reg + LOOK_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    re_reg <= in_real;
                    im_reg <= in_imag;
                end
            end
            F_SQ_RE: begin
                sq_reg  <= square[SQ_W-1:0];
                mag_reg <= MAG_W'(abs_re);
            end
            F_SQ_IM: begin
                sq_reg   <= sq_reg + square[SQ_W-1:0];
                rem_reg  <= '0;
                root_reg <= '0;
                step_reg <= STEP_W'(ROOT_W - 1);
            end
            F_ROOT: begin
                rem_reg  <= fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
                root_reg <= root_step;
                sq_reg   <= {sq_reg[SQ_W-3:0], 2'b00};
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == '0) mag_reg <= MAG_W'(root_step);
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- rtl/evd_queue.sv -----
// Two-entry queue of magnitudes between front and back end.
module evd_queue
    import evd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [MAG_W-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [MAG_W-1:0] rd_data
);

    logic [MAG_W-1:0] slot_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             push, pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ----- rtl/evd_back.sv -----
// Back end: one-pole attack/release recursion and the result register.
module evd_back
    import evd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              mag_valid,
    output logic              mag_ready,
    input  logic [MAG_W-1:0]  mag_data,
    input  logic [GAIN_W-1:0] attack_gain,
    input  logic [GAIN_W-1:0] release_gain,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [OUT_W-1:0]  out_data
);

    back_state_t       state_reg, state_next;
    logic [MAG_W-1:0]  mag_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [MUL_W-1:0]  comp_reg;    // one minus gain
    logic [ENV_W-1:0]  env_reg;
    logic [ENV_W:0]    acc_reg;
    logic [OUT_W-1:0]  out_reg;
    logic              out_valid_reg;

    logic              take;
    logic              load_out;
    logic              rising;
    logic [GAIN_W-1:0] gain_sel;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] prod;

    assign rising   = {mag_data, ENV_FRAC'(0)} > env_reg;
    assign gain_sel = rising ? attack_gain : release_gain;
    assign prod     = mul_a * mul_b;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:    if (mag_valid) state_next = B_MUL_LO;
            B_MUL_LO:  state_next = B_MUL_HI;
            B_MUL_HI:  state_next = B_MUL_MAG;
            B_MUL_MAG: state_next = B_OUT;
            B_OUT:     if (!out_valid_reg || out_ready) state_next = B_IDLE;
            default:   state_next = B_IDLE;
        endcase
    end

    // env*g is split into low and high halves so one 17x17 multiplier serves
    always_comb begin
        mag_ready = (state_reg == B_IDLE);
        take      = mag_valid && mag_ready;
        load_out  = (state_reg == B_OUT) && (!out_valid_reg || out_ready);
        mul_a     = {1'b0, gain_reg};
        mul_b     = {1'b0, env_reg[ENV_FRAC-1:0]};
        case (state_reg)
            B_MUL_HI: begin
                mul_b = env_reg[ENV_W-1:ENV_FRAC];
            end
            B_MUL_MAG: begin
                mul_a = comp_reg;
                mul_b = mag_reg;
            end
            default: begin
            end
        endcase
        out_valid = out_valid_reg;
        out_data  = out_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            env_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                env_reg       <= acc_reg[ENV_W-1:0];
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            mag_reg  <= mag_data;
            gain_reg <= gain_sel;
            comp_reg <= GAIN_ONE - {1'b0, gain_sel};
        end
        case (state_reg)
            B_MUL_LO:  acc_reg <= (ENV_W + 1)'(prod[2*ENV_FRAC-1:ENV_FRAC]);
            B_MUL_HI:  acc_reg <= acc_reg + (ENV_W + 1)'(prod);
            B_MUL_MAG: acc_reg <= acc_reg + (ENV_W + 1)'(prod);
            default: begin
            end
        endcase
        if (load_out) out_reg <= acc_reg[ENV_W-1:OUT_SHIFT];
    end

endmodule

// ----- rtl/envelope_detector_attack_release_top.sv -----
// Attack/release envelope detector: registers, front end, queue, back end.
// Each end takes a new sample only after finishing the last; lookahead samples are dropped.
// Front end: F_SQ_RE, F_PUSH for real samples; F_SQ_RE, F_SQ_IM, 16-step square root, F_PUSH
// for complex ones. Back end per sample: B_MUL_LO, B_MUL_HI, B_MUL_MAG, B_OUT.
// Reset: synchronous, active low; registers to 1, 59294, 59294, 10, envelope and count to zero.
module envelope_detector_attack_release_top
    import evd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,     // sample_real[15:0], sample_imag[31:16]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,     // envelope_value[24:0], zero pad
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic              complex_reg;
    logic [GAIN_W-1:0] attack_reg, release_reg;
    logic [LOOK_W-1:0] look_reg;

    logic              q_in_valid, q_in_ready, q_out_valid, q_out_ready;
    logic [MAG_W-1:0]  q_in_data, q_out_data;
    logic [OUT_W-1:0]  env_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            complex_reg <= RST_COMPLEX;
            attack_reg  <= RST_ATTACK;
            release_reg <= RST_RELEASE;
            look_reg    <= RST_LOOKAHEAD;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_COMPLEX:   complex_reg <= cfg_data[0];
                CFG_ATTACK:    attack_reg  <= cfg_data[GAIN_W-1:0];
                CFG_RELEASE:   release_reg <= cfg_data[GAIN_W-1:0];
                CFG_LOOKAHEAD: look_reg    <= cfg_data[LOOK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    evd_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_real         (s_tdata[SAMPLE_W-1:0]),
        .in_imag         (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .complex_input   (complex_reg),
        .lookahead_count (look_reg),
        .mag_valid       (q_in_valid),
        .mag_ready       (q_in_ready),
        .mag_data        (q_in_data)
    );

    evd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (q_in_valid),
        .wr_ready (q_in_ready),
        .wr_data  (q_in_data),
        .rd_valid (q_out_valid),
        .rd_ready (q_out_ready),
        .rd_data  (q_out_data)
    );

    evd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .mag_valid    (q_out_valid),
        .mag_ready    (q_out_ready),
        .mag_data     (q_out_data),
        .attack_gain  (attack_reg),
        .release_gain (release_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_data     (env_out)
    );

    assign m_tdata = {(32 - OUT_W)'(0), env_out};

endmodule
